@@ hdl/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// bls_pkg
// Shared constants, types and helpers for the line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

   localparam int COORD_WIDTH_DEFAULT = 16;

   // command codes carried in the cmd field
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // per-point attributes that do not depend on the coordinate width
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] rect_width;
      logic [7:0] rect_height;
      logic       last;
   } attr_type;

   // floor(1.5 * t), saturated at 255
   function automatic logic [7:0] rect_height_of(input logic [7:0] t);
      logic [8:0] sum;
      sum = {1'b0, t} + {2'b00, t[7:1]};
      return sum[8] ? 8'hFF : sum[7:0];
   endfunction

endpackage

@@ hdl/bls_req_if.sv @@
// ----------------------------------------------------------------------------
// bls_req_if
// Command channel of the line stepper: start and step commands.
// ----------------------------------------------------------------------------
interface bls_req_if #(
   parameter int COORD_WIDTH = bls_pkg::COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;
   logic [7:0]                    red;
   logic [7:0]                    green;
   logic [7:0]                    blue;
   logic [7:0]                    thickness;

   modport source (
      output valid, cmd, start_x, start_y, end_x, end_y, red, green, blue, thickness,
      input  ready
   );
   modport sink (
      input  valid, cmd, start_x, start_y, end_x, end_y, red, green, blue, thickness,
      output ready
   );
endinterface

// ----------------------------------------------------------------------------
// bls_rsp_if
// Point channel of the line stepper.
// ----------------------------------------------------------------------------
interface bls_rsp_if #(
   parameter int COORD_WIDTH = bls_pkg::COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic [7:0]                    out_red;
   logic [7:0]                    out_green;
   logic [7:0]                    out_blue;
   logic [7:0]                    rect_width;
   logic [7:0]                    rect_height;
   logic                          last;

   modport source (
      output valid, point_x, point_y, out_red, out_green, out_blue,
             rect_width, rect_height, last,
      input  ready
   );
   modport sink (
      input  valid, point_x, point_y, out_red, out_green, out_blue,
             rect_width, rect_height, last,
      output ready
   );
endinterface

@@ hdl/bls_walk.sv @@
// ----------------------------------------------------------------------------
// bls_walk
// Line state, set by a start beat, and one Bresenham step per accepted step beat while a line is active.
// ----------------------------------------------------------------------------
module bls_walk #(
   parameter int COORD_WIDTH = bls_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          cmd,
   input  logic signed [COORD_WIDTH-1:0] start_x,
   input  logic signed [COORD_WIDTH-1:0] start_y,
   input  logic signed [COORD_WIDTH-1:0] end_x,
   input  logic signed [COORD_WIDTH-1:0] end_y,
   input  logic [7:0]                    red,
   input  logic [7:0]                    green,
   input  logic [7:0]                    blue,
   input  logic [7:0]                    thickness,
   output logic                          emit,
   output logic signed [COORD_WIDTH-1:0] point_x,
   output logic signed [COORD_WIDTH-1:0] point_y,
   output bls_pkg::attr_type             attr
);
   import bls_pkg::*;

   localparam int EW = COORD_WIDTH + 2;

   logic signed [COORD_WIDTH-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_WIDTH-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [COORD_WIDTH-1:0]        dist_x_ff, dist_x_in, dist_y_ff, dist_y_in;
   logic                          dir_x_neg_ff, dir_x_neg_in, dir_y_neg_ff, dir_y_neg_in;
   logic signed [EW-1:0]          error_ff, error_in;
   logic                          active_ff, active_in;
   logic [7:0]                    red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [7:0]                    thick_ff, thick_in;

   logic                          is_start;
   logic signed [COORD_WIDTH:0]   diff_x, diff_y;
   logic [COORD_WIDTH-1:0]        abs_x, abs_y;
   logic signed [EW-1:0]          dx_ext, dy_ext, half_dx, half_dy;
   logic                          move_x, move_y;
   logic signed [EW-1:0]          err_step;
   logic signed [COORD_WIDTH-1:0] step_x, step_y;
   logic                          at_goal;

   assign is_start = (cmd == CMD_START);
   assign emit     = accept && (is_start || active_ff);

   // start: distances, directions and the initial error term
   assign diff_x = $signed({end_x[COORD_WIDTH-1], end_x})
                 - $signed({start_x[COORD_WIDTH-1], start_x});
   assign diff_y = $signed({end_y[COORD_WIDTH-1], end_y})
                 - $signed({start_y[COORD_WIDTH-1], start_y});
   assign abs_x  = diff_x[COORD_WIDTH] ? COORD_WIDTH'(-diff_x) : diff_x[COORD_WIDTH-1:0];
   assign abs_y  = diff_y[COORD_WIDTH] ? COORD_WIDTH'(-diff_y) : diff_y[COORD_WIDTH-1:0];
   assign half_dx = $signed({3'b000, abs_x[COORD_WIDTH-1:1]});
   assign half_dy = $signed({3'b000, abs_y[COORD_WIDTH-1:1]});

   // step: both tests use the old error term
   assign dx_ext   = $signed({2'b00, dist_x_ff});
   assign dy_ext   = $signed({2'b00, dist_y_ff});
   assign move_x   = (error_ff > -dx_ext);
   assign move_y   = (error_ff < dy_ext);
   assign err_step = error_ff - (move_x ? dy_ext : EW'(0)) + (move_y ? dx_ext : EW'(0));
   assign step_x   = !move_x ? cur_x_ff
                   : (dir_x_neg_ff ? cur_x_ff - COORD_WIDTH'(1) : cur_x_ff + COORD_WIDTH'(1));
   assign step_y   = !move_y ? cur_y_ff
                   : (dir_y_neg_ff ? cur_y_ff - COORD_WIDTH'(1) : cur_y_ff + COORD_WIDTH'(1));

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      dist_x_in    = dist_x_ff;
      dist_y_in    = dist_y_ff;
      dir_x_neg_in = dir_x_neg_ff;
      dir_y_neg_in = dir_y_neg_ff;
      error_in     = error_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      thick_in     = thick_ff;
      if (emit && is_start) begin
         cur_x_in     = start_x;
         cur_y_in     = start_y;
         goal_x_in    = end_x;
         goal_y_in    = end_y;
         dist_x_in    = abs_x;
         dist_y_in    = abs_y;
         dir_x_neg_in = !(start_x < end_x);
         dir_y_neg_in = !(start_y < end_y);
         error_in     = (abs_x > abs_y) ? half_dx : -half_dy;
         red_in       = red;
         green_in     = green;
         blue_in      = blue;
         thick_in     = thickness;
      end else if (emit) begin
         cur_x_in = step_x;
         cur_y_in = step_y;
         error_in = err_step;
      end
   end

   assign at_goal   = (cur_x_in == goal_x_in) && (cur_y_in == goal_y_in);
   assign active_in = emit ? !at_goal : active_ff;

   assign point_x          = cur_x_in;
   assign point_y          = cur_y_in;
   assign attr.red         = red_in;
   assign attr.green       = green_in;
   assign attr.blue        = blue_in;
   assign attr.rect_width  = thick_in;
   assign attr.rect_height = rect_height_of(thick_in);
   assign attr.last        = at_goal;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         dist_x_ff    <= '0;
         dist_y_ff    <= '0;
         dir_x_neg_ff <= 1'b0;
         dir_y_neg_ff <= 1'b0;
         error_ff     <= '0;
         active_ff    <= 1'b0;
         red_ff       <= '0;
         green_ff     <= '0;
         blue_ff      <= '0;
         thick_ff     <= '0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         dist_x_ff    <= dist_x_in;
         dist_y_ff    <= dist_y_in;
         dir_x_neg_ff <= dir_x_neg_in;
         dir_y_neg_ff <= dir_y_neg_in;
         error_ff     <= error_in;
         active_ff    <= active_in;
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         thick_ff     <= thick_in;
      end
   end

   // an active line never sits on its end point
   a_active_off_goal: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> !((cur_x_ff == goal_x_ff) && (cur_y_ff == goal_y_ff)))
      else $error("active line sits on its end point");

   // the end point closes the line
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      emit && attr.last |=> !active_ff)
      else $error("line still active after last point");

   // a step without a line leaves the walk untouched
   a_idle_step_hold: assert property (@(posedge clock) disable iff (reset)
      accept && (cmd == CMD_STEP) && !active_ff |=>
         $stable(cur_x_ff) && $stable(cur_y_ff) && $stable(error_ff) && !active_ff)
      else $error("idle step changed line state");

endmodule

@@ hdl/bls_out.sv @@
// ----------------------------------------------------------------------------
// bls_out
// Result register: holds one point until the sink takes it.
// ----------------------------------------------------------------------------
module bls_out #(
   parameter int COORD_WIDTH = bls_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   input  bls_pkg::attr_type             attr,
   output logic                          space,
   bls_rsp_if.source                     rsp_bus
);
   import bls_pkg::*;

   logic                          valid_ff, valid_in;
   logic signed [COORD_WIDTH-1:0] x_ff, y_ff;
   attr_type                      attr_ff;

   // room for a new beat when empty or the held beat leaves now
   assign space    = !valid_ff || rsp_bus.ready;
   assign valid_in = load || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff    <= point_x;
         y_ff    <= point_y;
         attr_ff <= attr;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.point_x     = x_ff;
   assign rsp_bus.point_y     = y_ff;
   assign rsp_bus.out_red     = attr_ff.red;
   assign rsp_bus.out_green   = attr_ff.green;
   assign rsp_bus.out_blue    = attr_ff.blue;
   assign rsp_bus.rect_width  = attr_ff.rect_width;
   assign rsp_bus.rect_height = attr_ff.rect_height;
   assign rsp_bus.last        = attr_ff.last;

   // never overwrite a point the sink has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> space)
      else $error("result overwritten while held");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded point not presented");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !valid_ff)
      else $error("result valid after reset");

endmodule

@@ hdl/bresenham_line_stepper_unit.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_stepper_unit
// Bresenham line point generator: start latches a line, each step gives
// the next point with color and paint rectangle size.
//
//   channel   dir   handshake            beat
//   req_bus   in    valid/ready          cmd, endpoints, color, thickness
//   rsp_bus   out   valid/ready          point, color, rect size, last
//
// One command per cycle while req_bus.ready is high; a point appears on rsp_bus in the cycle after its
// command is taken, from the result register fed by the step datapath.
// req_bus.ready is low only while a held point is stalled by rsp_bus.
// A step with no line in progress is taken and gives no point.
// Synchronous reset clears the line state and empties the result register.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_unit #(
   parameter int COORD_WIDTH = bls_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   bls_req_if.sink   req_bus,
   bls_rsp_if.source rsp_bus
);
   import bls_pkg::*;

   logic                          accept;
   logic                          emit;
   logic                          space;
   logic signed [COORD_WIDTH-1:0] point_x, point_y;
   attr_type                      attr;

   assign req_bus.ready = space;
   assign accept        = req_bus.valid && space;

   bls_walk #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_bus.cmd),
      .start_x   (req_bus.start_x),
      .start_y   (req_bus.start_y),
      .end_x     (req_bus.end_x),
      .end_y     (req_bus.end_y),
      .red       (req_bus.red),
      .green     (req_bus.green),
      .blue      (req_bus.blue),
      .thickness (req_bus.thickness),
      .emit      (emit),
      .point_x   (point_x),
      .point_y   (point_y),
      .attr      (attr)
   );

   bls_out #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_out (
      .clock   (clock),
      .reset   (reset),
      .load    (emit),
      .point_x (point_x),
      .point_y (point_y),
      .attr    (attr),
      .space   (space),
      .rsp_bus (rsp_bus)
   );

endmodule
